### rtl/core/psl_pkg.sv
// Shared types and constants for the per-sensor loss and range statistics block.
`timescale 1ns / 1ps
`default_nettype none

package psl_pkg;

    localparam int ID_W    = 4;
    localparam int SEQ_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 32;
    localparam int SUM_W   = 64;
    localparam int IN_W    = SEQ_W + VAL_W;
    localparam int ENTRY_W = 3 * CNT_W + 2 * VAL_W + SUM_W;

    // One table entry; the last member sits in the lowest bits.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum_value;
        logic signed [VAL_W-1:0] max_value;
        logic signed [VAL_W-1:0] min_value;
        logic        [SEQ_W-1:0] high_seq;
        logic        [CNT_W-1:0] lost;
        logic        [CNT_W-1:0] received;
    } t_entry;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } t_state;

endpackage

`default_nettype wire

### rtl/core/psl_entry_update.sv
// Read-modify-write arithmetic for one sensor table entry.
`timescale 1ns / 1ps
`default_nettype none

module psl_entry_update (
    input  wire logic                         i_tracked,
    input  wire psl_pkg::t_entry              i_old,
    input  wire logic [psl_pkg::SEQ_W-1:0]    i_seq,
    input  wire logic signed [psl_pkg::VAL_W-1:0] i_value,
    output psl_pkg::t_entry                   o_new
);
    import psl_pkg::*;

    logic [SEQ_W:0]   seq33;
    logic [SEQ_W:0]   last33;
    logic             gap_hit;
    logic [SEQ_W-1:0] gap;
    logic [CNT_W:0]   lost_sum;
    logic signed [SUM_W-1:0] val_ext;
    logic signed [SUM_W-1:0] sum_raw;
    logic             sum_ovf;
    t_entry           upd;

    always_comb begin
        seq33    = {1'b0, i_seq};
        last33   = {1'b0, i_old.high_seq};
        gap_hit  = seq33 > (last33 + (SEQ_W+1)'(1));
        gap      = i_seq - i_old.high_seq - SEQ_W'(1);
        lost_sum = {1'b0, i_old.lost} + {1'b0, gap};
        val_ext  = SUM_W'(i_value);
        sum_raw  = i_old.sum_value + val_ext;
        // Overflow when both operands share a sign that the result lacks.
        sum_ovf  = (i_old.sum_value[SUM_W-1] == val_ext[SUM_W-1])
                && (sum_raw[SUM_W-1] != val_ext[SUM_W-1]);

        upd.received = (&i_old.received) ? i_old.received : i_old.received + CNT_W'(1);
        if (gap_hit) begin
            upd.lost = lost_sum[CNT_W] ? {CNT_W{1'b1}} : lost_sum[CNT_W-1:0];
        end else begin
            upd.lost = i_old.lost;
        end
        upd.high_seq  = (i_seq > i_old.high_seq) ? i_seq : i_old.high_seq;
        upd.min_value = (i_value < i_old.min_value) ? i_value : i_old.min_value;
        upd.max_value = (i_value > i_old.max_value) ? i_value : i_old.max_value;
        if (sum_ovf) begin
            upd.sum_value = val_ext[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                             : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            upd.sum_value = sum_raw;
        end

        if (i_tracked) begin
            o_new = upd;
        end else begin
            o_new.received  = CNT_W'(1);
            o_new.lost      = '0;
            o_new.high_seq  = i_seq;
            o_new.min_value = i_value;
            o_new.max_value = i_value;
            o_new.sum_value = val_ext;
        end
    end

endmodule

`default_nettype wire

### rtl/core/per_sensor_loss_and_range_stats.sv
// Top level: per-sensor packet loss counters with min, max and sum of sample values.
// An accepted item's entry is read into a register; the result is loaded in the
// update state once the output register is free. A new item is taken only in the
// idle state, after the last one is updated and written back to the table.
// Reset (synchronous, active low) clears the control state and the per-sensor
// tracked flags; the table contents stay undefined and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module per_sensor_loss_and_range_stats #(
    parameter int SENSORS = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input item: tdata = seq[31:0], value[63:32]; tuser = sensor_id[3:0].
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [psl_pkg::IN_W-1:0]      i_s_axis_tdata,
    input  wire logic [psl_pkg::ID_W-1:0]      i_s_axis_tuser,
    // Result item: tdata = received[31:0], lost[63:32], high_seq[95:64],
    // min_value[127:96], max_value[159:128], sum_value[223:160];
    // tuser = accepted[0].
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [psl_pkg::ENTRY_W-1:0]        o_m_axis_tdata,
    output logic                               o_m_axis_tuser
);
    import psl_pkg::*;

    localparam int IDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam logic [ID_W:0] SENSORS_L = (ID_W+1)'(SENSORS);

    // Control state.
    t_state r_state, n_state;
    logic   r_out_valid;
    logic [SENSORS-1:0] r_tracked;

    // Item held while its entry is read and updated.
    logic                    r_id_ok;
    logic [IDX_W-1:0]        r_idx;
    logic [SEQ_W-1:0]        r_seq;
    logic signed [VAL_W-1:0] r_value;

    // Sensor table: one entry per sensor, registered read port.
    t_entry r_mem [SENSORS];
    t_entry r_rd_entry;

    t_entry r_out_entry;
    logic   r_out_accepted;

    logic   in_fire;
    logic   load_out;
    logic   in_id_ok;
    logic [IDX_W-1:0] in_idx;
    t_entry new_entry;

    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign in_id_ok = {1'b0, i_s_axis_tuser} < SENSORS_L;
    assign in_idx   = i_s_axis_tuser[IDX_W-1:0];

    // The update finishes once the output register is free or being emptied.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // No item is taken while reset is held.
    always_comb begin
        o_s_axis_tready = 1'b0;
        load_out        = 1'b0;
        case (r_state)
            ST_IDLE: o_s_axis_tready = i_rst_n;
            ST_CALC: load_out = !r_out_valid || i_m_axis_tready;
            default: begin
                o_s_axis_tready = 1'b0;
                load_out        = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_tracked   <= '0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (load_out && r_id_ok) begin
                r_tracked[r_idx] <= 1'b1;
            end
        end
    end

    // Item capture and table read; the read address is the incoming sensor.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_id_ok    <= in_id_ok;
            r_idx      <= in_idx;
            r_seq      <= i_s_axis_tdata[SEQ_W-1:0];
            r_value    <= i_s_axis_tdata[IN_W-1:SEQ_W];
            r_rd_entry <= r_mem[in_idx];
        end
    end

    psl_entry_update u_update (
        .i_tracked (r_tracked[r_idx]),
        .i_old     (r_rd_entry),
        .i_seq     (r_seq),
        .i_value   (r_value),
        .o_new     (new_entry)
    );

    // Write-back happens in the same cycle the result is loaded. The table is read
    // only in the idle state, after the write-back in the update state, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (load_out && r_id_ok) begin
            r_mem[r_idx] <= new_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_accepted <= r_id_ok;
            r_out_entry    <= r_id_ok ? new_entry : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_entry;
    assign o_m_axis_tuser  = r_out_accepted;

    // An accepted item always moves into the update cycle.
    a_fire_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_CALC))
        else $error("accepted item did not enter the update cycle");

    // A new result only appears right after an update cycle.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == ST_CALC))
        else $error("result appeared without an update cycle");

    // A rejected sensor gives an all-zero result.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("rejected sensor produced nonzero statistics");

    // An updated entry has counted at least one report.
    a_received_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[CNT_W-1:0] != '0))
        else $error("updated entry reports zero received");

endmodule

`default_nettype wire
